// ===== hw/rtl/tgi_pkg.sv =====
// Shared types and constants of the trilinear grid interpolator.
package tgi_pkg;

    localparam int GRID_NODES  = 32768;
    localparam int ADDR_BITS   = $clog2(GRID_NODES);
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FBITS       = FRAC_BITS + 1;
    localparam int CELL_BITS   = 8;
    localparam int P1_BITS     = 16;
    localparam int BASE_BITS   = 24;
    localparam int SXY_BITS    = 17;
    localparam int CADDR_BITS  = 25;
    localparam int CORNERS     = 8;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [FBITS-1:0] FRAC_ONE = FBITS'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_Z = 2'd2;

    localparam logic [CELL_BITS-1:0] CELLS_RESET = 8'd31;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [FBITS-1:0]              t_frac;
    typedef logic [CELL_BITS-1:0]          t_cell;

endpackage

// ===== hw/rtl/tgi_ram.sv =====
// Generic memory with one write port and two registered read ports.
module tgi_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hw/rtl/tgi_addr.sv =====
// Two-stage base address generator and per-axis range check.
module tgi_addr (
    input  logic                              i_clk,
    input  tgi_pkg::t_cell                    i_x,
    input  tgi_pkg::t_cell                    i_y,
    input  tgi_pkg::t_cell                    i_z,
    input  tgi_pkg::t_cell                    i_cells_x,
    input  tgi_pkg::t_cell                    i_cells_y,
    input  tgi_pkg::t_cell                    i_cells_z,
    output logic [tgi_pkg::BASE_BITS-1:0]     o_base,
    output logic [tgi_pkg::CELL_BITS:0]       o_stride_z,
    output logic [tgi_pkg::SXY_BITS-1:0]      o_stride_xy,
    output logic                              o_oor
);

    logic [tgi_pkg::CELL_BITS:0]   sy;
    logic [tgi_pkg::CELL_BITS:0]   sz;
    logic [tgi_pkg::P1_BITS-1:0]   r_p1;
    tgi_pkg::t_cell                r_z1;
    logic                          r_oor1;
    logic [tgi_pkg::BASE_BITS-1:0] r_base;
    logic                          r_oor2;
    logic [tgi_pkg::SXY_BITS-1:0]  r_sxy;

    assign sy = {1'b0, i_cells_y} + 9'd1;
    assign sz = {1'b0, i_cells_z} + 9'd1;

    always_ff @(posedge i_clk) begin
        r_p1   <= tgi_pkg::P1_BITS'(i_x * sy) + tgi_pkg::P1_BITS'(i_y);
        r_z1   <= i_z;
        // A lower corner at or beyond the last node leaves the far corner outside.
        r_oor1 <= (i_x >= i_cells_x) || (i_y >= i_cells_y) || (i_z >= i_cells_z);
        r_base <= tgi_pkg::BASE_BITS'(r_p1 * sz) + tgi_pkg::BASE_BITS'(r_z1);
        r_oor2 <= r_oor1;
        r_sxy  <= tgi_pkg::SXY_BITS'(sy * sz);
    end

    assign o_base      = r_base;
    assign o_stride_z  = sz;
    assign o_stride_xy = r_sxy;
    assign o_oor       = r_oor2;

endmodule

// ===== hw/rtl/tgi_lerp.sv =====
// One registered lerp v0 + (v1 - v0) * f, rounded to nearest, ties upward.
module tgi_lerp (
    input  logic            i_clk,
    input  tgi_pkg::t_sample i_v0,
    input  tgi_pkg::t_sample i_v1,
    input  tgi_pkg::t_frac   i_frac,
    output tgi_pkg::t_sample o_v
);

    localparam int DW = tgi_pkg::SAMPLE_BITS + 1;
    localparam int PW = DW + tgi_pkg::FBITS + 1;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] num;
    logic signed [PW-1:0] rnd;

    assign diff = DW'(i_v1) - DW'(i_v0);
    assign prod = PW'(diff) * $signed({1'b0, i_frac});
    assign num  = (PW'(i_v0) <<< tgi_pkg::FRAC_BITS) + prod;
    assign rnd  = (num + (PW'(1) <<< (tgi_pkg::FRAC_BITS - 1))) >>> tgi_pkg::FRAC_BITS;

    // The blend lies between its operands, so the low bits hold it exactly.
    always_ff @(posedge i_clk) begin
        o_v <= rnd[tgi_pkg::SAMPLE_BITS-1:0];
    end

endmodule

// ===== hw/rtl/trilinear_grid_interpolator.sv =====
// Top level of the trilinear grid interpolator.
// Usage: an item is taken at a rising edge with start high and busy low;
// busy is always low, so one item may enter every cycle. Opcode 0 writes
// sample_value at node_address and gives no result. Opcode 1 blends the
// eight corners of the named cell, first along z, then y, then x.
// An interpolate result shows on o_interpolated_value and o_out_of_range
// for one cycle with o_strobe high. Throughput is one item per clock:
// the address path is two multiplier stages, the eight corners come from
// four replicated two-read-port node memories in the same read, and each
// lerp level is one registered stage. Writes reach the memories at the
// same pipeline step as corner reads, so items see each other's effects
// in acceptance order. Configuration writes on i_cfg_we take effect at
// once; the user must make them only while no item is in flight, as the
// block does not enforce it. Reset sets every cell count to 31 and
// empties the pipeline; node memory contents are undefined until written.
// Results cannot be held off by the receiver; none is buffered.
module trilinear_grid_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic [tgi_pkg::ADDR_BITS-1:0]       i_node_address,
    input  logic signed [tgi_pkg::SAMPLE_BITS-1:0] i_sample_value,
    input  logic [tgi_pkg::CELL_BITS-1:0]       i_cell_x,
    input  logic [tgi_pkg::CELL_BITS-1:0]       i_cell_y,
    input  logic [tgi_pkg::CELL_BITS-1:0]       i_cell_z,
    input  logic [tgi_pkg::FBITS-1:0]           i_frac_x,
    input  logic [tgi_pkg::FBITS-1:0]           i_frac_y,
    input  logic [tgi_pkg::FBITS-1:0]           i_frac_z,
    input  logic                                i_cfg_we,
    input  logic [tgi_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [tgi_pkg::CELL_BITS-1:0]       i_cfg_data,
    output logic                                o_strobe,
    output logic signed [tgi_pkg::SAMPLE_BITS-1:0] o_interpolated_value,
    output logic                                o_out_of_range
);

    localparam int NLAT = 7;

    tgi_pkg::t_cell r_cells_x, r_cells_y, r_cells_z;

    logic accept;
    logic [NLAT-1:0] r_vld;
    logic [2:0]      r_wr;

    logic [tgi_pkg::ADDR_BITS-1:0] r_waddr [3];
    tgi_pkg::t_sample              r_wdata [3];

    tgi_pkg::t_cell r_x0, r_y0, r_z0;
    tgi_pkg::t_frac r_fx [6];
    tgi_pkg::t_frac r_fy [5];
    tgi_pkg::t_frac r_fz [4];
    logic [3:0]     r_oor;

    logic [tgi_pkg::BASE_BITS-1:0] base;
    logic [tgi_pkg::CELL_BITS:0]   stride_z;
    logic [tgi_pkg::SXY_BITS-1:0]  stride_xy;
    logic                          oor_axis;
    logic [tgi_pkg::CADDR_BITS-1:0] caddr [tgi_pkg::CORNERS];
    tgi_pkg::t_sample              corner [tgi_pkg::CORNERS];
    tgi_pkg::t_sample              vz [4];
    tgi_pkg::t_sample              vy [2];
    tgi_pkg::t_sample              vx;

    function automatic tgi_pkg::t_frac clamp_frac(input tgi_pkg::t_frac f);
        clamp_frac = (f > tgi_pkg::FRAC_ONE) ? tgi_pkg::FRAC_ONE : f;
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= tgi_pkg::CELLS_RESET;
            r_cells_y <= tgi_pkg::CELLS_RESET;
            r_cells_z <= tgi_pkg::CELLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tgi_pkg::CFG_CELLS_X: r_cells_x <= i_cfg_data;
                tgi_pkg::CFG_CELLS_Y: r_cells_y <= i_cfg_data;
                tgi_pkg::CFG_CELLS_Z: r_cells_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_wr  <= '0;
        end else begin
            r_vld <= {r_vld[NLAT-2:0], accept && (i_opcode == tgi_pkg::OP_INTERP)};
            r_wr  <= {r_wr[1:0], accept && (i_opcode == tgi_pkg::OP_WRITE)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr[0] <= i_node_address;
        r_wdata[0] <= i_sample_value;
        for (int i = 1; i < 3; i++) begin
            r_waddr[i] <= r_waddr[i-1];
            r_wdata[i] <= r_wdata[i-1];
        end
        r_x0 <= i_cell_x;
        r_y0 <= i_cell_y;
        r_z0 <= i_cell_z;
        r_fx[0] <= clamp_frac(i_frac_x);
        r_fy[0] <= clamp_frac(i_frac_y);
        r_fz[0] <= clamp_frac(i_frac_z);
        for (int i = 1; i < 6; i++) r_fx[i] <= r_fx[i-1];
        for (int i = 1; i < 5; i++) r_fy[i] <= r_fy[i-1];
        for (int i = 1; i < 4; i++) r_fz[i] <= r_fz[i-1];
        // The far corner has the largest address, so it alone is checked.
        r_oor[0] <= oor_axis ||
                    (caddr[tgi_pkg::CORNERS-1] >= tgi_pkg::CADDR_BITS'(tgi_pkg::GRID_NODES));
        for (int i = 1; i < 4; i++) r_oor[i] <= r_oor[i-1];
    end

    tgi_addr u_addr (
        .i_clk       (i_clk),
        .i_x         (r_x0),
        .i_y         (r_y0),
        .i_z         (r_z0),
        .i_cells_x   (r_cells_x),
        .i_cells_y   (r_cells_y),
        .i_cells_z   (r_cells_z),
        .o_base      (base),
        .o_stride_z  (stride_z),
        .o_stride_xy (stride_xy),
        .o_oor       (oor_axis)
    );

    always_comb begin
        for (int i = 0; i < tgi_pkg::CORNERS; i++) begin
            caddr[i] = tgi_pkg::CADDR_BITS'(base)
                     + (i[2] ? tgi_pkg::CADDR_BITS'(stride_xy) : '0)
                     + (i[1] ? tgi_pkg::CADDR_BITS'(stride_z) : '0)
                     + tgi_pkg::CADDR_BITS'(i[0]);
        end
    end

    for (genvar k = 0; k < tgi_pkg::CORNERS / 2; k++) begin : g_bank
        tgi_ram #(
            .DEPTH (tgi_pkg::GRID_NODES),
            .WIDTH (tgi_pkg::SAMPLE_BITS)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (r_wr[2]),
            .i_waddr   (r_waddr[2]),
            .i_wdata   (r_wdata[2]),
            .i_raddr_a (caddr[2*k][tgi_pkg::ADDR_BITS-1:0]),
            .i_raddr_b (caddr[2*k+1][tgi_pkg::ADDR_BITS-1:0]),
            .o_rdata_a (corner[2*k]),
            .o_rdata_b (corner[2*k+1])
        );
        tgi_lerp u_lerp_z (
            .i_clk  (i_clk),
            .i_v0   (corner[2*k]),
            .i_v1   (corner[2*k+1]),
            .i_frac (r_fz[3]),
            .o_v    (vz[k])
        );
    end

    for (genvar k = 0; k < 2; k++) begin : g_lerp_y
        tgi_lerp u_lerp_y (
            .i_clk  (i_clk),
            .i_v0   (vz[2*k]),
            .i_v1   (vz[2*k+1]),
            .i_frac (r_fy[4]),
            .o_v    (vy[k])
        );
    end

    tgi_lerp u_lerp_x (
        .i_clk  (i_clk),
        .i_v0   (vy[0]),
        .i_v1   (vy[1]),
        .i_frac (r_fx[5]),
        .o_v    (vx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_vld[NLAT-1];
        end
        o_interpolated_value <= r_oor[3] ? '0 : vx;
        o_out_of_range       <= r_oor[3];
    end

    a_strobe_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && (i_opcode == tgi_pkg::OP_INTERP), NLAT + 1))
        else $error("result strobe without a matching interpolate item");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_of_range) |-> (o_interpolated_value == '0))
        else $error("out-of-range result carries a nonzero value");

    a_slot_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr[2] && r_vld[2]))
        else $error("write and interpolate share one pipeline slot");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

// ===== dv/trilinear_grid_interpolator_checker.sv =====
// Checker for the trilinear grid interpolator: predicts each interpolation and compares results.
module trilinear_grid_interpolator_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                i_opcode,
    input  logic [tgi_pkg::ADDR_BITS-1:0]       i_node_address,
    input  tgi_pkg::t_sample                    i_sample_value,
    input  tgi_pkg::t_cell                      i_cell_x,
    input  tgi_pkg::t_cell                      i_cell_y,
    input  tgi_pkg::t_cell                      i_cell_z,
    input  tgi_pkg::t_frac                      i_frac_x,
    input  tgi_pkg::t_frac                      i_frac_y,
    input  tgi_pkg::t_frac                      i_frac_z,
    input  logic                                i_cfg_we,
    input  logic [tgi_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  tgi_pkg::t_cell                      i_cfg_data,
    input  logic                                o_strobe,
    input  tgi_pkg::t_sample                    o_interpolated_value,
    input  logic                                o_out_of_range,
    output int                                  o_pending,
    output int                                  o_errors,
    output int                                  o_oor_seen
);

    typedef struct {
        tgi_pkg::t_sample value;
        logic             oor;
    } t_blend;

    t_blend           blend_q[$];
    tgi_pkg::t_sample node_mem[int];
    tgi_pkg::t_cell   cells_x, cells_y, cells_z;

    function automatic longint clamp_offset(tgi_pkg::t_frac f);
        return (f > tgi_pkg::FRAC_ONE) ? longint'(tgi_pkg::FRAC_ONE) : longint'(f);
    endfunction

    // Exact weighted sum, then divide by one with rounding to nearest, ties upward.
    function automatic longint mix(longint a, longint b, longint f);
        longint num;
        num = a * ((longint'(1) << tgi_pkg::FRAC_BITS) - f) + b * f;
        return (num + (longint'(1) << (tgi_pkg::FRAC_BITS - 1))) >>> tgi_pkg::FRAC_BITS;
    endfunction

    function automatic t_blend blend_cell(tgi_pkg::t_cell x, tgi_pkg::t_cell y,
                                          tgi_pkg::t_cell z, tgi_pkg::t_frac frx,
                                          tgi_pkg::t_frac fry, tgi_pkg::t_frac frz);
        t_blend r;
        longint sy, sz, fx, fy, fz, a;
        longint c[8];
        longint vz[4];
        longint vy[2];
        sy = longint'(cells_y) + 1;
        sz = longint'(cells_z) + 1;
        fx = clamp_offset(frx);
        fy = clamp_offset(fry);
        fz = clamp_offset(frz);
        r.value = '0;
        r.oor = 1'b1;
        if (x + 1 > cells_x || y + 1 > cells_y || z + 1 > cells_z ||
            ((longint'(x) + 1) * sy + y + 1) * sz + z + 1 >= tgi_pkg::GRID_NODES)
            return r;
        for (int i = 0; i < 8; i++) begin
            a = ((longint'(x) + i[2]) * sy + y + i[1]) * sz + z + i[0];
            c[i] = node_mem.exists(int'(a)) ? longint'(node_mem[int'(a)]) : 0;
        end
        for (int i = 0; i < 4; i++)
            vz[i] = mix(c[2*i], c[2*i+1], fz);
        vy[0] = mix(vz[0], vz[1], fy);
        vy[1] = mix(vz[2], vz[3], fy);
        r.value = tgi_pkg::t_sample'(mix(vy[0], vy[1], fx));
        r.oor = 1'b0;
        return r;
    endfunction

    assign o_pending = blend_q.size();

    always @(posedge i_clk) begin
        t_blend want;
        if (!i_rst_n) begin
            cells_x = tgi_pkg::CELLS_RESET;
            cells_y = tgi_pkg::CELLS_RESET;
            cells_z = tgi_pkg::CELLS_RESET;
            o_errors = 0;
            o_oor_seen = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tgi_pkg::CFG_CELLS_X: cells_x = i_cfg_data;
                    tgi_pkg::CFG_CELLS_Y: cells_y = i_cfg_data;
                    tgi_pkg::CFG_CELLS_Z: cells_z = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_opcode == tgi_pkg::OP_WRITE)
                    node_mem[int'(i_node_address)] = i_sample_value;
                else
                    blend_q.push_back(blend_cell(i_cell_x, i_cell_y, i_cell_z,
                                                 i_frac_x, i_frac_y, i_frac_z));
            end
            if (o_strobe) begin
                if (blend_q.size() == 0) begin
                    $display("%0t: result with nothing expected: value %0d oor %0b",
                             $time, o_interpolated_value, o_out_of_range);
                    o_errors++;
                end else begin
                    want = blend_q.pop_front();
                    if (want.oor) o_oor_seen++;
                    if (o_interpolated_value !== want.value) begin
                        $display("%0t: interpolated_value expected %0d actual %0d",
                                 $time, want.value, o_interpolated_value);
                        o_errors++;
                    end
                    if (o_out_of_range !== want.oor) begin
                        $display("%0t: out_of_range expected %0b actual %0b",
                                 $time, want.oor, o_out_of_range);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/trilinear_grid_interpolator_tb.sv =====
// Testbench top for the trilinear grid interpolator: stimulus, watchdog and verdict.
module trilinear_grid_interpolator_tb;

    localparam int STALL_LIMIT = 2000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic                             i_opcode = tgi_pkg::OP_WRITE;
    logic [tgi_pkg::ADDR_BITS-1:0]    i_node_address = '0;
    tgi_pkg::t_sample                 i_sample_value = '0;
    tgi_pkg::t_cell                   i_cell_x = '0, i_cell_y = '0, i_cell_z = '0;
    tgi_pkg::t_frac                   i_frac_x = '0, i_frac_y = '0, i_frac_z = '0;
    logic                             i_cfg_we = 1'b0;
    logic [tgi_pkg::CFG_IDX_BITS-1:0] i_cfg_index = tgi_pkg::CFG_CELLS_X;
    tgi_pkg::t_cell                   i_cfg_data = '0;
    logic                             o_strobe;
    tgi_pkg::t_sample                 o_interpolated_value;
    logic                             o_out_of_range;
    int                               pending, errors, oor_seen;

    int  idle_pct = 0;
    int  grid_x = 31, grid_y = 31, grid_z = 31;
    bit  written [tgi_pkg::GRID_NODES];
    int  n_writes = 0, n_blends = 0;
    int  stall_cycles = 0;

    always #2 i_clk = ~i_clk;

    trilinear_grid_interpolator dut (.*);

    trilinear_grid_interpolator_checker checker_i (
        .*, .o_pending(pending), .o_errors(errors), .o_oor_seen(oor_seen));

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n || i_cfg_we)
            stall_cycles = 0;
        else if (++stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("trilinear_grid_interpolator_tb: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue();
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic put_node(int addr, tgi_pkg::t_sample v);
        i_opcode = tgi_pkg::OP_WRITE;
        i_node_address = addr[tgi_pkg::ADDR_BITS-1:0];
        i_sample_value = v;
        i_cell_x = tgi_pkg::t_cell'($urandom);
        i_frac_x = tgi_pkg::t_frac'($urandom);
        written[addr] = 1'b1;
        n_writes++;
        issue();
    endtask

    function automatic longint node_addr(int x, int y, int z);
        return ((longint'(x) * (grid_y + 1)) + y) * (grid_z + 1) + z;
    endfunction

    // Writes unwritten corners of an in-range cell first; no unwritten node is read.
    task automatic blend_at(int x, int y, int z, tgi_pkg::t_frac fx, tgi_pkg::t_frac fy,
                            tgi_pkg::t_frac fz);
        longint a;
        if (x + 1 <= grid_x && y + 1 <= grid_y && z + 1 <= grid_z &&
            node_addr(x + 1, y + 1, z + 1) < tgi_pkg::GRID_NODES) begin
            for (int i = 0; i < 8; i++) begin
                a = node_addr(x + i[2], y + i[1], z + i[0]);
                if (!written[a]) put_node(int'(a), tgi_pkg::t_sample'($urandom));
            end
        end
        i_opcode = tgi_pkg::OP_INTERP;
        i_node_address = tgi_pkg::ADDR_BITS'($urandom);
        i_sample_value = tgi_pkg::t_sample'($urandom);
        i_cell_x = tgi_pkg::t_cell'(x);
        i_cell_y = tgi_pkg::t_cell'(y);
        i_cell_z = tgi_pkg::t_cell'(z);
        i_frac_x = fx;
        i_frac_y = fy;
        i_frac_z = fz;
        n_blends++;
        issue();
    endtask

    task automatic set_grid(int cx, int cy, int cz);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = tgi_pkg::CFG_CELLS_X;
        i_cfg_data = tgi_pkg::t_cell'(cx);
        @(negedge i_clk);
        i_cfg_index = tgi_pkg::CFG_CELLS_Y;
        i_cfg_data = tgi_pkg::t_cell'(cy);
        @(negedge i_clk);
        i_cfg_index = tgi_pkg::CFG_CELLS_Z;
        i_cfg_data = tgi_pkg::t_cell'(cz);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        grid_x = cx; grid_y = cy; grid_z = cz;
    endtask

    function automatic tgi_pkg::t_frac any_offset();
        case ($urandom_range(5))
            0: return '0;
            1: return tgi_pkg::FRAC_ONE;
            2: return tgi_pkg::t_frac'($urandom);
            default: return tgi_pkg::t_frac'($urandom_range(65536));
        endcase
    endfunction

    task automatic random_phase(int count);
        int x, y, z;
        repeat (count) begin
            case ($urandom_range(19))
                0, 1, 2:
                    put_node($urandom_range(tgi_pkg::GRID_NODES - 1),
                             tgi_pkg::t_sample'($urandom));
                3, 4, 5:
                    blend_at($urandom_range(254), $urandom_range(254),
                             $urandom_range(254), any_offset(), any_offset(), any_offset());
                default: begin
                    x = (grid_x > 0) ? $urandom_range(grid_x - 1) : 0;
                    y = (grid_y > 0) ? $urandom_range(grid_y - 1) : 0;
                    z = (grid_z > 0) ? $urandom_range(grid_z - 1) : 0;
                    blend_at(x, y, z, any_offset(), any_offset(), any_offset());
                end
            endcase
        end
    endtask

    initial begin
        int cfg_list [7][3] = '{'{31, 31, 31}, '{1, 1, 1}, '{255, 1, 1}, '{2, 255, 3},
                               '{255, 255, 255}, '{0, 7, 7}, '{5, 9, 12}};
        int pct_list [7] = '{0, 61, 0, 34, 61, 0, 34};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme samples on one cell, edge offsets, clamping, grid edges.
        put_node(0, 32'sh7fffffff);
        put_node(1, 32'sh80000000);
        put_node(tgi_pkg::GRID_NODES - 1, 32'sh80000000);
        blend_at(0, 0, 0, '0, '0, '0);
        blend_at(0, 0, 0, tgi_pkg::FRAC_ONE, tgi_pkg::FRAC_ONE, tgi_pkg::FRAC_ONE);
        blend_at(0, 0, 0, 17'h1ffff, 17'h10001, 17'h08000);
        blend_at(0, 0, 0, 17'h08000, 17'h08000, 17'h08000);
        blend_at(0, 0, 0, 17'h00001, 17'h0ffff, 17'h08000);
        blend_at(30, 30, 30, 17'h0ffff, 17'h00001, 17'h1ffff);
        blend_at(31, 0, 0, tgi_pkg::FRAC_ONE, '0, '0);
        blend_at(0, 31, 0, '0, tgi_pkg::FRAC_ONE, '0);
        blend_at(0, 0, 31, '0, '0, tgi_pkg::FRAC_ONE);
        blend_at(254, 254, 254, 17'h1ffff, 17'h1ffff, 17'h1ffff);

        for (int p = 0; p < 7; p++) begin
            set_grid(cfg_list[p][0], cfg_list[p][1], cfg_list[p][2]);
            idle_pct = pct_list[p];
            if (cfg_list[p][0] == 255 && cfg_list[p][1] == 1)
                blend_at(254, 0, 0, tgi_pkg::FRAC_ONE, '0, 17'h1ffff);
            random_phase(45);
        end

        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        $display("Covered %0d node writes and %0d interpolations (%0d out of range)",
                 n_writes, n_blends, oor_seen);
        $display("over seven grid shapes, including single-cell, zero and full-size axes.");
        if (errors == 0)
            $display("trilinear_grid_interpolator_tb: done, clean");
        else
            $display("trilinear_grid_interpolator_tb: done, errors");
        $finish;
    end

endmodule
